/* rtl/ibs_pkg.sv */
// shared types and constants of the 3x3 box smoother
package ibs_pkg;

   localparam int CFG_W      = 11;
   localparam int ROW_W      = 10;
   localparam int OCOL_W     = 10;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_HEIGHT = 1024;
   localparam int REG_RESET  = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOAD = 3'b010,
      S_EMIT = 3'b100
   } ibs_state_type;

   // per-result descriptor passed from front to back
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [OCOL_W-1:0] col;
      logic [CNT_W-1:0]  cnt;
      logic              last;
      logic              done;
   } ibs_meta_type;

endpackage

/* rtl/ibs_if.sv */
// channel interfaces: pixel in, smoothed result out, register writes
interface ibs_req_if #(parameter int PIXEL_BITS = 8);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_value;
   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface ibs_rsp_if #(parameter int PIXEL_BITS = 8);
   logic                  valid;
   logic                  ready;
   logic [9:0]            out_row;
   logic [9:0]            out_col;
   logic [PIXEL_BITS-1:0] smoothed_value;
   logic                  run_last;
   logic                  frame_done;
   modport source (output valid, output out_row, output out_col, output smoothed_value,
                   output run_last, output frame_done, input ready);
   modport sink   (input valid, input out_row, input out_col, input smoothed_value,
                   input run_last, input frame_done, output ready);
endinterface

interface ibs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [10:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/ibs_fifo.sv */
// four-word queue between the front and the back
module ibs_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   localparam int DEPTH = 4;
   localparam int PTR_W = 2;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

/* rtl/ibs_front.sv */
// front end: line stores, window, counters and result descriptors
module ibs_front import ibs_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8,
   parameter int SUM_W      = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   ibs_req_if.sink                 req_chan,
   input  logic [CFG_W-1:0]        frame_width,
   input  logic [CFG_W-1:0]        frame_height,
   output logic                    push_valid,
   output ibs_meta_type            push_meta,
   output logic [SUM_W-1:0]        push_sum,
   input  logic                    push_full
);
   localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W = $clog2(MAX_WIDTH + 1);

   logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];

   ibs_state_type         state_ff, state_in;
   logic [IDX_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [IDX_W-1:0]      j_ff;
   logic [ROW_W-1:0]      i_ff;
   logic [PIXEL_BITS-1:0] px_ff;
   logic [PIXEL_BITS-1:0] rd_up_ff, rd_lo_ff;
   logic [PIXEL_BITS-1:0] win_ff [3][3];
   logic [3:0]            mask_ff, mask_in, mask_now, mask_rest;

   logic [WID_W-1:0]      w_eff, w_m1;
   logic [CFG_W-1:0]      h_eff, h_m1;
   logic [IDX_W-1:0]      j_cur;
   logic [ROW_W-1:0]      i_cur;
   logic                  accept, j_last, i_last;
   logic [1:0]            k_sel;
   logic                  sel_upper, sel_right;
   logic [1:0]            r0, c0, nrows, ncols;
   logic [SUM_W-1:0]      sum;

   // clamp out-of-range register values
   always_comb begin
      if (frame_width == '0) begin
         w_eff = WID_W'(1);
      end else if (32'(frame_width) > MAX_WIDTH) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(frame_width);
      end
      if (frame_height == '0) begin
         h_eff = CFG_W'(1);
      end else if (32'(frame_height) > MAX_HEIGHT) begin
         h_eff = CFG_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height;
      end
      w_m1 = w_eff - 1'b1;
      h_m1 = h_eff - 1'b1;
   end

   assign j_cur  = (WID_W'(col_ff) < w_eff) ? col_ff : IDX_W'(w_m1);
   assign i_cur  = (CFG_W'(row_ff) < h_eff) ? row_ff : ROW_W'(h_m1);
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign j_last = (WID_W'(j_ff) == w_m1);
   assign i_last = (CFG_W'(i_ff) == h_m1);

   always_comb begin
      mask_now[0] = (i_ff != '0) && (j_ff != '0);
      mask_now[1] = (i_ff != '0) && j_last;
      mask_now[2] = i_last && (j_ff != '0);
      mask_now[3] = i_last && j_last;
   end

   // pick the first pending result in raster order
   always_comb begin
      if (mask_ff[0]) begin
         k_sel = 2'd0;
      end else if (mask_ff[1]) begin
         k_sel = 2'd1;
      end else if (mask_ff[2]) begin
         k_sel = 2'd2;
      end else begin
         k_sel = 2'd3;
      end
      mask_rest        = mask_ff;
      mask_rest[k_sel] = 1'b0;
      sel_upper        = !k_sel[1];
      sel_right        = k_sel[0];
   end

   always_comb begin
      if (sel_upper) begin
         r0 = (i_ff > ROW_W'(1)) ? 2'd0 : 2'd1;
      end else begin
         r0 = (i_ff != '0) ? 2'd1 : 2'd2;
      end
      if (sel_right) begin
         c0 = (j_ff != '0) ? 2'd1 : 2'd2;
      end else begin
         c0 = (j_ff > IDX_W'(1)) ? 2'd0 : 2'd1;
      end
      nrows = 2'd3 - r0;
      ncols = 2'd3 - c0;
   end

   always_comb begin
      sum = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((2'(r) >= r0) && (2'(c) >= c0)) begin
               sum = sum + SUM_W'(win_ff[r][c]);
            end
         end
      end
   end

   always_comb begin
      push_meta.row  = sel_upper ? i_ff - 1'b1 : i_ff;
      push_meta.col  = sel_right ? OCOL_W'(j_ff) : OCOL_W'(j_ff - 1'b1);
      push_meta.cnt  = {2'b00, nrows} * {2'b00, ncols};
      push_meta.last = (mask_rest == '0);
      push_meta.done = (k_sel == 2'd3);
      push_sum       = sum;
      push_valid     = (state_ff == S_EMIT);
   end

   always_comb begin
      state_in = state_ff;
      mask_in  = mask_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            mask_in  = mask_now;
            state_in = (mask_now != '0) ? S_EMIT : S_IDLE;
            if (j_last) begin
               col_in = '0;
               row_in = i_last ? '0 : i_ff + 1'b1;
            end else begin
               col_in = j_ff + 1'b1;
               row_in = i_ff;
            end
         end
         S_EMIT: begin
            if (!push_full) begin
               mask_in = mask_rest;
               if (mask_rest == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mask_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mask_ff  <= mask_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= req_chan.pixel_value;
         j_ff  <= j_cur;
         i_ff  <= i_cur;
      end
   end

   // window shifts left, new column enters on the right
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (state_ff == S_LOAD) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= rd_up_ff;
         win_ff[1][2] <= rd_lo_ff;
         win_ff[2][2] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD) begin
         upper_mem[j_ff] <= rd_lo_ff;
      end
      if (accept) begin
         rd_up_ff <= upper_mem[j_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD) begin
         lower_mem[j_ff] <= px_ff;
      end
      if (accept) begin
         rd_lo_ff <= lower_mem[j_cur];
      end
   end
endmodule

/* rtl/ibs_back.sv */
// back end: divide sum by count and hold the result word
module ibs_back import ibs_pkg::*; #(
   parameter int PIXEL_BITS = 8,
   parameter int SUM_W      = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  ibs_meta_type     pop_meta,
   input  logic [SUM_W-1:0] pop_sum,
   ibs_rsp_if.source        rsp_chan
);
   localparam int K  = SUM_W + 4;
   localparam int RW = K + 1;
   localparam int PW = SUM_W + RW;

   // ceil(2^K / n): exact floor division for sums below 2^SUM_W and n up to 9
   localparam logic [RW-1:0] RECIP [16] = '{
      RW'(0),
      RW'((2**K + 0) / 1), RW'((2**K + 1) / 2), RW'((2**K + 2) / 3),
      RW'((2**K + 3) / 4), RW'((2**K + 4) / 5), RW'((2**K + 5) / 6),
      RW'((2**K + 6) / 7), RW'((2**K + 7) / 8), RW'((2**K + 8) / 9),
      RW'(0), RW'(0), RW'(0), RW'(0), RW'(0), RW'(0)
   };

   logic                  valid_ff, valid_in;
   ibs_meta_type          meta_ff;
   logic [PIXEL_BITS-1:0] value_ff;
   logic [PW-1:0]         prod;

   assign pop_ready = !valid_ff || rsp_chan.ready;
   assign prod      = PW'(pop_sum) * PW'(RECIP[pop_meta.cnt]);

   always_comb begin
      valid_in = valid_ff;
      if (pop_ready) begin
         valid_in = pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         meta_ff  <= pop_meta;
         value_ff <= prod[K +: PIXEL_BITS];
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.out_row        = meta_ff.row;
   assign rsp_chan.out_col        = meta_ff.col;
   assign rsp_chan.smoothed_value = value_ff;
   assign rsp_chan.run_last       = meta_ff.last;
   assign rsp_chan.frame_done     = meta_ff.done;
endmodule

/* rtl/image_box_smoother_3x3.sv */
// 3x3 box smoother top level: register port, front end, queue, back end
// pace set by the front sequencer and its line store port: a new pixel is taken
//    only when idle, after the last is loaded and its results (up to 4) emitted
// result path: front load and emit states (a full queue stalls emission), queue, output register
// reset: counters, window and queue cleared, frame size back to 1024 x 1024,
//    line stores not cleared (no clearing pass)
module image_box_smoother_3x3 import ibs_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   ibs_req_if.sink   req_chan,
   ibs_rsp_if.source rsp_chan,
   ibs_csr_if.sink   csr_chan
);
   // sum of up to nine pixels
   localparam int SUM_W  = PIXEL_BITS + 4;
   localparam int META_W = $bits(ibs_meta_type);
   localparam int Q_W    = META_W + SUM_W;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             csr_write;

   // front to queue
   logic             push_valid, push_full;
   ibs_meta_type     push_meta;
   logic [SUM_W-1:0] push_sum;

   // queue to back
   logic             pop_valid, pop_ready;
   logic [Q_W-1:0]   pop_word;
   ibs_meta_type     pop_meta;
   logic [SUM_W-1:0] pop_sum;

   // register writes are always taken
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_chan.index)
            CSR_FRAME_WIDTH:  width_in  = csr_chan.data;
            CSR_FRAME_HEIGHT: height_in = csr_chan.data;
            default: begin
               // unmapped index: word dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(REG_RESET);
         height_ff <= CFG_W'(REG_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // front: takes pixels, updates line stores and window, lists the results
   ibs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS),
      .SUM_W      (SUM_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .push_valid   (push_valid),
      .push_meta    (push_meta),
      .push_sum     (push_sum),
      .push_full    (push_full)
   );

   // short queue so the front keeps going while the output is stalled
   ibs_fifo #(
      .DATA_W (Q_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_meta, push_sum}),
      .full       (push_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_word)
   );

   assign pop_meta = pop_word[Q_W-1 -: META_W];
   assign pop_sum  = pop_word[SUM_W-1:0];

   // back: reciprocal multiply for the mean, output register
   ibs_back #(
      .PIXEL_BITS (PIXEL_BITS),
      .SUM_W      (SUM_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_meta  (pop_meta),
      .pop_sum   (pop_sum),
      .rsp_chan  (rsp_chan)
   );
endmodule

/* dv/testbench.sv */
// self-checking testbench for the 3x3 box smoother: frames of random and edge pixels
module testbench;
   import ibs_pkg::*;

   localparam int LINE_MAX   = 1024;
   localparam int IDLE_LIMIT = 20000;   // cycles with no word moving on any channel

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct {
      logic [9:0] row;
      logic [9:0] col;
      logic [7:0] value;
      logic       run_last;
      logic       frame_done;
   } smooth_word_type;

   // frame predictor plus the queue of smoothed words still owed by the block
   class smooth_scoreboard;
      int unsigned width_reg  = REG_RESET;
      int unsigned height_reg = REG_RESET;
      int unsigned upper_line [LINE_MAX];
      int unsigned lower_line [LINE_MAX];
      int unsigned win [3][3];
      int unsigned col_pos;
      int unsigned row_pos;
      smooth_word_type owed [$];
      int errors;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         if (idx == CSR_FRAME_WIDTH) width_reg = data;
         else if (idx == CSR_FRAME_HEIGHT) height_reg = data;
      endfunction

      function int unsigned box_mean(int unsigned r0, int unsigned c0, int unsigned c1);
         int unsigned sum;
         int unsigned cnt;
         sum = 0;
         cnt = 0;
         for (int r = r0; r < 3; r++) begin
            for (int c = c0; c <= c1; c++) begin
               sum += win[r][c];
               cnt++;
            end
         end
         return sum / cnt;
      endfunction

      function void owe(int unsigned row, int unsigned col, int unsigned value, bit done);
         smooth_word_type w;
         w.row        = 10'(row);
         w.col        = 10'(col);
         w.value      = 8'(value);
         w.run_last   = 1'b0;
         w.frame_done = done;
         owed.push_back(w);
      endfunction

      // shift the new pixel into the window and queue every window it completes
      function void note_pixel(logic [7:0] px);
         int unsigned w, h, j, i, cleft, r0, start;
         w = (width_reg < 1) ? 1 : (width_reg > LINE_MAX ? LINE_MAX : width_reg);
         h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
         j = (col_pos < w) ? col_pos : w - 1;
         i = (row_pos < h) ? row_pos : h - 1;
         start = owed.size();
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         win[0][2] = upper_line[j];
         win[1][2] = lower_line[j];
         win[2][2] = px;
         upper_line[j] = lower_line[j];
         lower_line[j] = px;
         cleft = (j >= 2) ? 0 : 1;
         // row above is complete once the pixel below its right neighbour arrives
         if (i >= 1) begin
            r0 = (i >= 2) ? 0 : 1;
            if (j >= 1) owe(i - 1, j - 1, box_mean(r0, cleft, 2), 1'b0);
            if (j == w - 1) owe(i - 1, j, box_mean(r0, (j >= 1) ? 1 : 2, 2), 1'b0);
         end
         // bottom row has no row below, so it completes on its own pixels
         if (i == h - 1) begin
            r0 = (i >= 1) ? 1 : 2;
            if (j >= 1) owe(i, j - 1, box_mean(r0, cleft, 2), 1'b0);
            if (j == w - 1) owe(i, j, box_mean(r0, (j >= 1) ? 1 : 2, 2), 1'b1);
         end
         if (owed.size() > start) owed[owed.size()-1].run_last = 1'b1;
         if (j == w - 1) begin
            col_pos = 0;
            row_pos = (i == h - 1) ? 0 : i + 1;
         end else begin
            col_pos = j + 1;
            row_pos = i;
         end
      endfunction

      function void check_word(smooth_word_type got);
         smooth_word_type exp_w;
         if (owed.size() == 0) begin
            $error("unexpected word row %0d col %0d value %0d", got.row, got.col, got.value);
            errors++;
            return;
         end
         exp_w = owed.pop_front();
         if (got.row !== exp_w.row) begin
            $error("out_row: expected %0d, got %0d", exp_w.row, got.row);
            errors++;
         end
         if (got.col !== exp_w.col) begin
            $error("out_col: expected %0d, got %0d", exp_w.col, got.col);
            errors++;
         end
         if (got.value !== exp_w.value) begin
            $error("smoothed_value: expected %0d, got %0d", exp_w.value, got.value);
            errors++;
         end
         if (got.run_last !== exp_w.run_last) begin
            $error("run_last: expected %0b, got %0b", exp_w.run_last, got.run_last);
            errors++;
         end
         if (got.frame_done !== exp_w.frame_done) begin
            $error("frame_done: expected %0b, got %0b", exp_w.frame_done, got.frame_done);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ibs_req_if #(.PIXEL_BITS(8)) req ();
   ibs_rsp_if #(.PIXEL_BITS(8)) rsp ();
   ibs_csr_if csr ();

   image_box_smoother_3x3 DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   smooth_scoreboard board = new();

   bit calm;          // no idling in the closing part of the run
   bit long_hold;     // asks the receiver for one long stall
   int idle_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // receiver: ready drops in short random bursts, once for a long stretch
   initial begin
      int stall_left;
      stall_left = 0;
      rsp.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready = 1'b0;
         end else if (long_hold) begin
            long_hold  = 1'b0;
            stall_left = 199;
            rsp.ready  = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp.ready  = 1'b0;
         end else begin
            rsp.ready = 1'b1;
         end
      end
   end

   // every accepted word goes straight to the checker
   always @(posedge clock) begin
      smooth_word_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.row        = rsp.out_row;
         got.col        = rsp.out_col;
         got.value      = rsp.smoothed_value;
         got.run_last   = rsp.run_last;
         got.frame_done = rsp.frame_done;
         board.check_word(got);
      end
   end

   // watchdog: ends a run that stops moving words
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one pixel, maybe after a short gap, and hold it until accepted
   task automatic send_pixel(logic [7:0] px);
      int gap;
      gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid       = 1'b1;
      req.pixel_value = px;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_pixel(px);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
   endtask

   // register writes only with the block empty, after its latency has passed
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      drain();
      repeat (12) @(posedge clock);
      @(negedge clock);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data  = data;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      board.write_reg(idx, data);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one whole frame; pattern 1 is a checkerboard of the extremes
   task automatic run_frame(int w_reg, int h_reg, int pattern);
      int w, h;
      write_reg(CSR_FRAME_WIDTH, CFG_W'(w_reg));
      write_reg(CSR_FRAME_HEIGHT, CFG_W'(h_reg));
      w = (w_reg < 1) ? 1 : (w_reg > LINE_MAX ? LINE_MAX : w_reg);
      h = (h_reg < 1) ? 1 : (h_reg > MAX_HEIGHT ? MAX_HEIGHT : h_reg);
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (pattern == 1) send_pixel(((r + c) % 2) ? 8'd255 : 8'd0);
            else if (pattern == 2) send_pixel(8'd255);
            else send_pixel(rand_pixel());
         end
      end
   endtask

   initial begin
      int sent;
      int fw, fh;
      bit paused;
      reset       = 1'b1;
      calm        = 1'b0;
      long_hold   = 1'b0;
      paused      = 1'b0;
      req.valid   = 1'b0;
      req.pixel_value = '0;
      csr.valid   = 1'b0;
      csr.index   = '0;
      csr.data    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extreme pixels, small and one-line frames, out-of-range registers
      run_frame(3, 3, 1);
      run_frame(3, 3, 2);
      run_frame(0, 0, 0);
      run_frame(2, 2, 1);
      run_frame(30, 1, 0);
      run_frame(1, 30, 0);
      write_reg(CSR_SPARE_A, CFG_W'($urandom_range(0, 2047)));
      write_reg(CSR_SPARE_B, CFG_W'($urandom_range(0, 2047)));

      // random small frames, one long receiver stall and one sender pause inside
      sent = 0;
      while (sent < 400) begin
         fw = $urandom_range(1, 12);
         fh = $urandom_range(1, 8);
         write_reg(CSR_FRAME_WIDTH, CFG_W'(fw));
         write_reg(CSR_FRAME_HEIGHT, CFG_W'(fh));
         for (int p = 0; p < fw * fh; p++) begin
            if (sent == 120) long_hold = 1'b1;
            if (sent == 250 && !paused) begin
               paused = 1'b1;
               drain();
            end
            if (sent >= 340) calm = 1'b1;
            send_pixel(rand_pixel());
            sent++;
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
